// ===== sv/mpfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mpfb_pkg: shared constants for the page framebuffer engine
// Display geometry, store addressing and operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mpfb_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;

  localparam int ADDR_W  = $clog2(STORE_BYTES);
  localparam int COL_W   = $clog2(SCREEN_WIDTH);
  localparam int PAGE_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  // wide enough for start + size - 1 and for the screen limits
  localparam int COORD_W = 9;

  localparam logic [COORD_W-1:0] WIDTH_LIMIT  = COORD_W'(SCREEN_WIDTH);
  localparam logic [COORD_W-1:0] HEIGHT_LIMIT = COORD_W'(SCREEN_HEIGHT);

  typedef enum logic [1:0] {
    KIND_DRAW  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_FILL  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_270 = 2'd3;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [PAGE_W-1:0] page,
                                                   input logic [COL_W-1:0] col);
    store_addr = ADDR_W'(int'(page) * SCREEN_WIDTH + int'(col));
  endfunction

endpackage

`default_nettype wire

// ===== sv/mpfb_channels.sv =====
// ----------------------------------------------------------------------------
// mpfb channels: valid/ready interfaces for the framebuffer engine
// Command, response and rotation-register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpfb_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [6:0] pos_x;
  logic [6:0] pos_y;
  logic [7:0] size_x;
  logic [7:0] size_y;
  logic       color_on;

  modport source (output valid, kind, pos_x, pos_y, size_x, size_y, color_on,
                  input ready);
  modport sink   (input valid, kind, pos_x, pos_y, size_x, size_y, color_on,
                  output ready);
endinterface

interface mpfb_rsp_if;
  logic valid;
  logic ready;
  logic status;
  logic pixel_value;
  logic dirty;

  modport source (output valid, status, pixel_value, dirty, input ready);
  modport sink   (input valid, status, pixel_value, dirty, output ready);
endinterface

interface mpfb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== sv/mpfb_ram.sv =====
// ----------------------------------------------------------------------------
// mpfb_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/mono_page_framebuffer_engine_unit.sv =====
// ----------------------------------------------------------------------------
// mono_page_framebuffer_engine_unit: page-organized monochrome framebuffer
// Draw/read pixel, fill rectangle and clear-all on a byte-per-page store.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one operation word per handshake; rsp returns exactly one word
//   (status, pixel_value, dirty) per command, in order. cfg writes the 2-bit
//   rotation register; it is always ready and must only be written while idle.
// Operation steps:
//   Pixel draw/read: one store read, then a read-modify-write; the next command
//   can be taken at completion when rsp is not stalled.
//   Fill: each touched byte is read, then written back, one byte at a time,
//   bounded by the single store port pair.
//   Clear all: one write per byte, over all STORE_BYTES (1024 by default) bytes.
//   Rejected commands: no store access, straight to completion.
// Reset: rotation and the dirty flag go to 0; the store contents stay
//   undefined until written (no clearing pass).
// Stall: a finished response waits in the output register while the next
//   command runs; the engine holds at completion until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_page_framebuffer_engine_unit (
  input wire logic   clk,
  input wire logic   rst,
  mpfb_cfg_if.sink   cfg,
  mpfb_cmd_if.sink   cmd,
  mpfb_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PIX,
    S_FRD,
    S_FWR,
    S_CLR,
    S_DONE
  } state_t;

  state_t state;

  logic [1:0] rotation;
  logic       dirty;

  // staged response
  logic res_status;
  logic res_value;

  // pixel operation
  logic [mpfb_pkg::ADDR_W-1:0] pix_addr;
  logic [2:0]                  pix_bit;
  logic                        pix_draw;
  logic                        color;

  // fill walker
  logic [mpfb_pkg::COL_W-1:0]  col;
  logic [mpfb_pkg::COL_W-1:0]  col_start;
  logic [mpfb_pkg::COL_W-1:0]  col_end;
  logic [mpfb_pkg::PAGE_W-1:0] page;
  logic [mpfb_pkg::PAGE_W-1:0] page_start;
  logic [mpfb_pkg::PAGE_W-1:0] page_end;
  logic [2:0]                  sy_lo;
  logic [2:0]                  ey_lo;

  // clear sweep
  logic [mpfb_pkg::ADDR_W-1:0] sweep_addr;

  // command decode
  logic                         swap;
  logic [mpfb_pkg::COORD_W-1:0] px9, py9, ex0, ey0;
  logic [mpfb_pkg::COORD_W-1:0] pix_x, pix_y;
  logic [mpfb_pkg::COORD_W-1:0] fsx, fsy, fex, fey;
  logic                         pix_ok, fill_ok;
  logic                         slot_free, cmd_take;

  // store port
  logic                        ram_we;
  logic [mpfb_pkg::ADDR_W-1:0] ram_waddr;
  logic [7:0]                  ram_wdata;
  logic [mpfb_pkg::ADDR_W-1:0] ram_raddr;
  logic [7:0]                  ram_rdata;
  logic [7:0]                  pix_mask;
  logic [7:0]                  fill_mask;
  logic [mpfb_pkg::ADDR_W-1:0] fill_addr;

  assign swap      = (rotation == mpfb_pkg::ROT_90) || (rotation == mpfb_pkg::ROT_270);
  assign slot_free = !rsp.valid || rsp.ready;
  assign cmd.ready = (state == S_IDLE) || ((state == S_DONE) && slot_free);
  assign cmd_take  = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;

  always_comb begin
    px9 = {2'b00, cmd.pos_x};
    py9 = {2'b00, cmd.pos_y};
    pix_x = swap ? py9 : px9;
    pix_y = swap ? px9 : py9;
    pix_ok = (pix_x < mpfb_pkg::WIDTH_LIMIT) && (pix_y < mpfb_pkg::HEIGHT_LIMIT);
    ex0 = px9 + {1'b0, cmd.size_x} - 9'd1;
    ey0 = py9 + {1'b0, cmd.size_y} - 9'd1;
    fsx = swap ? py9 : px9;
    fsy = swap ? px9 : py9;
    fex = swap ? ey0 : ex0;
    fey = swap ? ex0 : ey0;
    fill_ok = (cmd.size_x != 8'd0) && (cmd.size_y != 8'd0) &&
              (fex < mpfb_pkg::WIDTH_LIMIT) && (fey < mpfb_pkg::HEIGHT_LIMIT);
  end

  always_comb begin
    fill_mask = 8'hff;
    if (page == page_start) begin
      fill_mask = fill_mask & (8'hff << sy_lo);
    end
    if (page == page_end) begin
      fill_mask = fill_mask & (8'hff >> (3'd7 - ey_lo));
    end
    pix_mask  = 8'h01 << pix_bit;
    fill_addr = mpfb_pkg::store_addr(page, col);
  end

  always_comb begin
    ram_raddr = (state == S_FRD) ? fill_addr :
                mpfb_pkg::store_addr(mpfb_pkg::PAGE_W'(pix_y >> 3),
                                     mpfb_pkg::COL_W'(pix_x));
    ram_we    = 1'b0;
    ram_waddr = fill_addr;
    ram_wdata = color ? (ram_rdata | fill_mask) : (ram_rdata & ~fill_mask);
    case (state)
      S_PIX: begin
        ram_we    = pix_draw;
        ram_waddr = pix_addr;
        ram_wdata = color ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
      end
      S_FWR: begin
        ram_we = 1'b1;
      end
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr;
        ram_wdata = color ? 8'hff : 8'h00;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  mpfb_ram #(
    .WIDTH(8),
    .DEPTH(mpfb_pkg::STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
      dirty     <= 1'b0;
      rotation  <= 2'd0;
    end else begin
      if (cfg.valid) begin
        rotation <= cfg.data;
      end
      if (state == S_DONE && slot_free) begin
        rsp.valid       <= 1'b1;
        rsp.status      <= res_status;
        rsp.pixel_value <= res_value;
        rsp.dirty       <= dirty;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE, S_DONE: begin
          if (cmd_take) begin
            color     <= cmd.color_on;
            res_value <= 1'b0;
            case (cmd.kind)
              mpfb_pkg::KIND_CLEAR: begin
                res_status <= 1'b0;
                sweep_addr <= '0;
                dirty      <= 1'b1;
                state      <= S_CLR;
              end
              mpfb_pkg::KIND_FILL: begin
                res_status <= !fill_ok;
                if (fill_ok) begin
                  col        <= mpfb_pkg::COL_W'(fsx);
                  col_start  <= mpfb_pkg::COL_W'(fsx);
                  col_end    <= mpfb_pkg::COL_W'(fex);
                  page       <= mpfb_pkg::PAGE_W'(fsy >> 3);
                  page_start <= mpfb_pkg::PAGE_W'(fsy >> 3);
                  page_end   <= mpfb_pkg::PAGE_W'(fey >> 3);
                  sy_lo      <= fsy[2:0];
                  ey_lo      <= fey[2:0];
                  dirty      <= 1'b1;
                  state      <= S_FRD;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                res_status <= !pix_ok;
                if (pix_ok) begin
                  pix_addr <= ram_raddr;
                  pix_bit  <= pix_y[2:0];
                  pix_draw <= (cmd.kind == mpfb_pkg::KIND_DRAW);
                  state    <= S_PIX;
                end else begin
                  state <= S_DONE;
                end
              end
            endcase
          end else if (state == S_DONE && slot_free) begin
            state <= S_IDLE;
          end
        end
        S_PIX: begin
          res_value <= pix_draw ? 1'b0 : ram_rdata[pix_bit];
          if (pix_draw) begin
            dirty <= 1'b1;
          end
          state <= S_DONE;
        end
        S_FRD: begin
          state <= S_FWR;
        end
        S_FWR: begin
          if (col == col_end) begin
            col <= col_start;
            if (page == page_end) begin
              state <= S_DONE;
            end else begin
              page  <= page + 1'b1;
              state <= S_FRD;
            end
          end else begin
            col   <= col + 1'b1;
            state <= S_FRD;
          end
        end
        S_CLR: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == mpfb_pkg::ADDR_W'(mpfb_pkg::STORE_BYTES - 1)) begin
            state <= S_DONE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // store writes only from the write-back steps
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_PIX || state == S_FWR || state == S_CLR))
    else $error("store write outside a write-back step");

  a_dirty_sticky: assert property (@(posedge clk) disable iff (rst)
    dirty |=> dirty)
    else $error("dirty flag fell without reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> state != S_IDLE)
    else $error("accepted command left engine idle");

  a_walk_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_FRD) |-> (col <= col_end && page <= page_end &&
                          col >= col_start && page >= page_start))
    else $error("fill walker outside rectangle");

endmodule

`default_nettype wire

// ===== verif/mono_page_framebuffer_engine_unit_tb.sv =====
// ----------------------------------------------------------------------------
// mono_page_framebuffer_engine_unit_tb: self-checking bench for the page
// framebuffer engine.
// A directed table runs first. Random operation words follow, in phases with
// several rotations and idle patterns. An in-bench shadow of the frame store
// predicts untyped response words; all responses are checked in order.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_engine_unit_tb;

  localparam int CLK_HALF    = 6;
  localparam int LIMIT_CYC   = 3_000_000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 225;
  localparam int SETTLE_CYC  = 8;
  localparam int MAX_REPORTS = 10;

  localparam logic ST_DONE   = 1'b0;
  localparam logic ST_REJECT = 1'b1;
  localparam logic CHK       = 1'b1;   // row carries a typed-in response
  localparam logic PRED      = 1'b0;   // row is checked against the shadow only

  localparam logic [1:0] PHASE_ROT [PHASES] = '{2'd0, 2'd3, 2'd1, 2'd2,
                                                2'd3, 2'd0, 2'd2, 2'd1};

  typedef struct packed {
    mpfb_pkg::kind_t kind;
    logic [6:0]      pos_x;
    logic [6:0]      pos_y;
    logic [7:0]      size_x;
    logic [7:0]      size_y;
    logic            color_on;
  } cmd_word_t;

  typedef struct packed {
    logic status;
    logic pixel_value;
    logic dirty;
  } rsp_word_t;

  typedef struct packed {
    logic [1:0] rot;
    cmd_word_t  word;
    logic       typed;
    rsp_word_t  res;
  } dir_row_t;

  localparam int DIR_ROWS = 26;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // still unwritten store: only rejected words allowed here
    {2'd0, mpfb_pkg::KIND_READ, 7'd0, 7'd64, 8'd1, 8'd1, 1'b0, CHK, ST_REJECT, 1'b0, 1'b0},
    {2'd0, mpfb_pkg::KIND_DRAW, 7'd127, 7'd127, 8'd1, 8'd1, 1'b1, CHK, ST_REJECT, 1'b0, 1'b0},
    {2'd0, mpfb_pkg::KIND_FILL, 7'd0, 7'd0, 8'd0, 8'd1, 1'b1, CHK, ST_REJECT, 1'b0, 1'b0},
    {2'd0, mpfb_pkg::KIND_FILL, 7'd0, 7'd0, 8'd1, 8'd0, 1'b1, CHK, ST_REJECT, 1'b0, 1'b0},
    {2'd0, mpfb_pkg::KIND_FILL, 7'd1, 7'd0, 8'd128, 8'd1, 1'b1, CHK, ST_REJECT, 1'b0, 1'b0},
    {2'd0, mpfb_pkg::KIND_FILL, 7'd0, 7'd0, 8'd255, 8'd255, 1'b1, CHK, ST_REJECT, 1'b0, 1'b0},
    // clear ignores coordinates and sizes
    {2'd0, mpfb_pkg::KIND_CLEAR, 7'd127, 7'd127, 8'd255, 8'd255, 1'b0, CHK, ST_DONE, 1'b0, 1'b1},
    {2'd0, mpfb_pkg::KIND_READ, 7'd0, 7'd0, 8'd1, 8'd1, 1'b0, CHK, ST_DONE, 1'b0, 1'b1},
    {2'd0, mpfb_pkg::KIND_DRAW, 7'd127, 7'd63, 8'd0, 8'd0, 1'b1, CHK, ST_DONE, 1'b0, 1'b1},
    {2'd0, mpfb_pkg::KIND_READ, 7'd127, 7'd63, 8'd0, 8'd0, 1'b0, CHK, ST_DONE, 1'b1, 1'b1},
    {2'd0, mpfb_pkg::KIND_READ, 7'd127, 7'd62, 8'd0, 8'd0, 1'b1, PRED, 3'b000},
    {2'd0, mpfb_pkg::KIND_FILL, 7'd0, 7'd0, 8'd128, 8'd64, 1'b1, CHK, ST_DONE, 1'b0, 1'b1},
    {2'd0, mpfb_pkg::KIND_READ, 7'd64, 7'd32, 8'd3, 8'd3, 1'b0, CHK, ST_DONE, 1'b1, 1'b1},
    // partial start and end pages
    {2'd0, mpfb_pkg::KIND_FILL, 7'd3, 7'd5, 8'd10, 8'd13, 1'b0, PRED, 3'b000},
    {2'd0, mpfb_pkg::KIND_READ, 7'd3, 7'd5, 8'd0, 8'd0, 1'b0, CHK, ST_DONE, 1'b0, 1'b1},
    {2'd0, mpfb_pkg::KIND_READ, 7'd3, 7'd4, 8'd0, 8'd0, 1'b0, CHK, ST_DONE, 1'b1, 1'b1},
    {2'd0, mpfb_pkg::KIND_FILL, 7'd60, 7'd9, 8'd1, 8'd1, 1'b0, PRED, 3'b000},
    {2'd0, mpfb_pkg::KIND_FILL, 7'd0, 7'd63, 8'd128, 8'd1, 1'b0, PRED, 3'b000},
    {2'd0, mpfb_pkg::KIND_CLEAR, 7'd0, 7'd0, 8'd0, 8'd0, 1'b1, CHK, ST_DONE, 1'b0, 1'b1},
    // swapped axes, then plain axes at rotation 2
    {2'd3, mpfb_pkg::KIND_DRAW, 7'd63, 7'd127, 8'd1, 8'd1, 1'b0, CHK, ST_DONE, 1'b0, 1'b1},
    {2'd3, mpfb_pkg::KIND_READ, 7'd63, 7'd127, 8'd1, 8'd1, 1'b1, CHK, ST_DONE, 1'b0, 1'b1},
    {2'd1, mpfb_pkg::KIND_READ, 7'd64, 7'd0, 8'd1, 8'd1, 1'b0, CHK, ST_REJECT, 1'b0, 1'b1},
    {2'd1, mpfb_pkg::KIND_FILL, 7'd0, 7'd0, 8'd64, 8'd128, 1'b0, CHK, ST_DONE, 1'b0, 1'b1},
    {2'd1, mpfb_pkg::KIND_FILL, 7'd0, 7'd0, 8'd65, 8'd1, 1'b1, CHK, ST_REJECT, 1'b0, 1'b1},
    {2'd2, mpfb_pkg::KIND_DRAW, 7'd127, 7'd63, 8'd1, 8'd1, 1'b1, CHK, ST_DONE, 1'b0, 1'b1},
    {2'd2, mpfb_pkg::KIND_READ, 7'd127, 7'd63, 8'd1, 8'd1, 1'b0, CHK, ST_DONE, 1'b1, 1'b1}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  mpfb_cfg_if cfg_if ();
  mpfb_cmd_if cmd_if ();
  mpfb_rsp_if rsp_if ();

  mono_page_framebuffer_engine_unit u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_if),
    .cmd (cmd_if),
    .rsp (rsp_if)
  );

  always #CLK_HALF clk = ~clk;

  // shadow of the engine state
  logic [7:0] frame_bytes [mpfb_pkg::STORE_BYTES];
  logic       dirty_now = 1'b0;
  logic [1:0] rot_now   = 2'd0;

  rsp_word_t  rsp_due_q [$];
  int         miss_count = 0;
  int         src_pct    = 0;
  int         snk_pct    = 0;

  function automatic logic axes_swapped();
    return rot_now == mpfb_pkg::ROT_90 || rot_now == mpfb_pkg::ROT_270;
  endfunction

  function automatic rsp_word_t frame_op_result(cmd_word_t w);
    int         x0, y0, x1, y1, t, pg, col, a;
    logic [7:0] mask;
    rsp_word_t  r;
    r = '0;
    case (w.kind)
      mpfb_pkg::KIND_CLEAR: begin
        for (a = 0; a < mpfb_pkg::STORE_BYTES; a++) frame_bytes[a] = {8{w.color_on}};
        dirty_now = 1'b1;
      end
      mpfb_pkg::KIND_FILL: begin
        if (w.size_x == 0 || w.size_y == 0) begin
          r.status = ST_REJECT;
        end else begin
          x0 = w.pos_x;
          y0 = w.pos_y;
          x1 = x0 + int'(w.size_x) - 1;
          y1 = y0 + int'(w.size_y) - 1;
          if (axes_swapped()) begin
            t = x0; x0 = y0; y0 = t;
            t = x1; x1 = y1; y1 = t;
          end
          if (x1 >= mpfb_pkg::SCREEN_WIDTH || y1 >= mpfb_pkg::SCREEN_HEIGHT) begin
            r.status = ST_REJECT;
          end else begin
            for (pg = y0 / 8; pg <= y1 / 8; pg++) begin
              mask = 8'hff;
              if (pg == y0 / 8) mask = mask & (8'hff << (y0 % 8));
              if (pg == y1 / 8) mask = mask & (8'hff >> (7 - y1 % 8));
              for (col = x0; col <= x1; col++) begin
                a = pg * mpfb_pkg::SCREEN_WIDTH + col;
                frame_bytes[a] = w.color_on ? (frame_bytes[a] | mask)
                                            : (frame_bytes[a] & ~mask);
              end
            end
            dirty_now = 1'b1;
          end
        end
      end
      default: begin
        x0 = w.pos_x;
        y0 = w.pos_y;
        if (axes_swapped()) begin
          t = x0; x0 = y0; y0 = t;
        end
        if (x0 >= mpfb_pkg::SCREEN_WIDTH || y0 >= mpfb_pkg::SCREEN_HEIGHT) begin
          r.status = ST_REJECT;
        end else begin
          a = (y0 / 8) * mpfb_pkg::SCREEN_WIDTH + x0;
          if (w.kind == mpfb_pkg::KIND_DRAW) begin
            frame_bytes[a][y0 % 8] = w.color_on;
            dirty_now = 1'b1;
          end else begin
            r.pixel_value = frame_bytes[a][y0 % 8];
          end
        end
      end
    endcase
    r.dirty = dirty_now;
    return r;
  endfunction

  // mostly in-range words, sized small; some noise to hit the reject paths
  function automatic cmd_word_t random_word();
    cmd_word_t w;
    int        roll, xlim, ylim, wd, ht;
    w.pos_x    = 7'($urandom);
    w.pos_y    = 7'($urandom);
    w.size_x   = 8'($urandom);
    w.size_y   = 8'($urandom);
    w.color_on = 1'($urandom);
    xlim = axes_swapped() ? mpfb_pkg::SCREEN_HEIGHT : mpfb_pkg::SCREEN_WIDTH;
    ylim = axes_swapped() ? mpfb_pkg::SCREEN_WIDTH : mpfb_pkg::SCREEN_HEIGHT;
    roll = $urandom_range(99);
    if (roll < 3) begin
      w.kind = mpfb_pkg::KIND_CLEAR;
    end else if (roll < 75) begin
      w.kind = (roll < 39) ? mpfb_pkg::KIND_READ : mpfb_pkg::KIND_DRAW;
      if ($urandom_range(99) >= 12) begin
        w.pos_x = 7'($urandom_range(xlim - 1));
        w.pos_y = 7'($urandom_range(ylim - 1));
      end
    end else begin
      w.kind = mpfb_pkg::KIND_FILL;
      if ($urandom_range(99) >= 12) begin
        roll = $urandom_range(99);
        wd = (roll < 85) ? $urandom_range(8, 1) :
             (roll < 97) ? $urandom_range(32, 1) : $urandom_range(xlim, 1);
        roll = $urandom_range(99);
        ht = (roll < 85) ? $urandom_range(8, 1) :
             (roll < 97) ? $urandom_range(32, 1) : $urandom_range(ylim, 1);
        w.size_x = 8'(wd);
        w.size_y = 8'(ht);
        w.pos_x  = 7'($urandom_range(xlim - wd));
        w.pos_y  = 7'($urandom_range(ylim - ht));
      end
    end
    return w;
  endfunction

  task automatic send_word(cmd_word_t w, logic typed, rsp_word_t res);
    rsp_word_t p;
    while (src_pct != 0 && $urandom_range(99) < src_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.kind     <= w.kind;
    cmd_if.pos_x    <= w.pos_x;
    cmd_if.pos_y    <= w.pos_y;
    cmd_if.size_x   <= w.size_x;
    cmd_if.size_y   <= w.size_y;
    cmd_if.color_on <= w.color_on;
    @(posedge clk);
    while (cmd_if.ready !== 1'b1) @(posedge clk);
    p = frame_op_result(w);
    rsp_due_q.push_back(typed ? res : p);
  endtask

  // hold the sender until every response word is back
  task automatic drain_rsp();
    cmd_if.valid <= 1'b0;
    while (rsp_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_rotation(logic [1:0] r);
    drain_rsp();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= r;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    cfg_if.valid <= 1'b0;
    rot_now = r;
  endtask

  task automatic check_rsp(rsp_word_t got);
    rsp_word_t want;
    if (rsp_due_q.size() == 0) begin
      miss_count++;
      if (miss_count <= MAX_REPORTS)
        $display("unexpected response word: status %0d pixel %0d dirty %0d",
                 got.status, got.pixel_value, got.dirty);
      return;
    end
    want = rsp_due_q.pop_front();
    if (got !== want) begin
      miss_count++;
      if (miss_count <= MAX_REPORTS)
        $display("response mismatch: exp status %0d pixel %0d dirty %0d, got %0d %0d %0d",
                 want.status, want.pixel_value, want.dirty,
                 got.status, got.pixel_value, got.dirty);
    end
  endtask

  // response sink: check on handshake, then pick the next ready level
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        check_rsp('{rsp_if.status, rsp_if.pixel_value, rsp_if.dirty});
      rsp_if.ready <= !(snk_pct != 0 && $urandom_range(99) < snk_pct);
    end
  end

  initial begin
    #(2 * CLK_HALF * LIMIT_CYC);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int ph, i;
    cmd_if.valid    <= 1'b0;
    cmd_if.kind     <= mpfb_pkg::KIND_DRAW;
    cmd_if.pos_x    <= '0;
    cmd_if.pos_y    <= '0;
    cmd_if.size_x   <= '0;
    cmd_if.size_y   <= '0;
    cmd_if.color_on <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.data     <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].rot != rot_now) set_rotation(DIRECTED[i].rot);
      send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].res);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      set_rotation(PHASE_ROT[ph]);
      case (ph % 4)
        0: begin src_pct = 0;  snk_pct = 0;  end
        1: begin src_pct = 64; snk_pct = 0;  end
        2: begin src_pct = 0;  snk_pct = 64; end
        default: begin src_pct = 18; snk_pct = 18; end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == PHASE_ITEMS / 2) drain_rsp();
        send_word(random_word(), PRED, '0);
      end
    end

    drain_rsp();
    repeat (SETTLE_CYC) @(posedge clk);
    if (miss_count == 0 && rsp_due_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mpfb_pkg.sv
sv/mpfb_channels.sv
sv/mpfb_ram.sv
sv/mono_page_framebuffer_engine_unit.sv
verif/mono_page_framebuffer_engine_unit_tb.sv
